>>> rtl/stc_pkg.sv
// shared constants, types and codes of the space-to-tab output compressor
package stc_pkg;

    // column range and derived widths
    localparam int MAX_COLUMN = 256;
    localparam int COL_W      = $clog2(MAX_COLUMN + 1);
    localparam int BYTE_W     = 8;
    localparam int GAP_W      = 8;
    localparam int CNT_W      = 9;
    localparam int CMP_W      = (COL_W > GAP_W) ? COL_W : GAP_W;

    localparam logic [COL_W-1:0] COL_MAX = COL_W'(MAX_COLUMN);

    // divider: quotient bits resolved per cycle
    localparam int DIV_BITS  = 3;
    localparam int DIV_CYC   = (COL_W + DIV_BITS - 1) / DIV_BITS;
    localparam int DIV_W     = DIV_CYC * DIV_BITS;
    localparam int DIV_CNT_W = $clog2(DIV_CYC + 1);

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_COMPRESS_ENABLE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_FILL_CHAR       = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_GAP             = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_SINGLE_SPACE    = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_PASS_THROUGH    = CFG_IDX_W'(4);

    // register reset values
    localparam logic [GAP_W-1:0] GAP_RESET = 8'd8;

    // byte codes
    localparam logic [BYTE_W-1:0] CH_BS       = 8'h08;
    localparam logic [BYTE_W-1:0] CH_TAB      = 8'h09;
    localparam logic [BYTE_W-1:0] CH_NL       = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR       = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_ESC      = 8'h1B;
    localparam logic [BYTE_W-1:0] CH_SPACE    = 8'h20;
    localparam logic [BYTE_W-1:0] CH_PRINT_LO = 8'h21;
    localparam logic [BYTE_W-1:0] CH_PRINT_HI = 8'h7E;

    // hardware tab stops every 8 columns
    localparam logic [COL_W-1:0] TAB_MASK = COL_W'(7);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_MOD,
        ST_DIV,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic decide;
        logic take_start;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic need_div;
        logic div_done;
        logic take;
        logic out_free;
    } t_status;

endpackage

>>> rtl/stc_div.sv
// iterative restoring divider, DIV_BITS quotient bits per cycle
module stc_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [stc_pkg::COL_W-1:0]   i_dividend,
    input  logic [stc_pkg::GAP_W-1:0]   i_divisor,
    output logic                        o_done,
    output logic [stc_pkg::COL_W-1:0]   o_quo,
    output logic [stc_pkg::GAP_W-1:0]   o_rem
);
    import stc_pkg::*;

    logic [DIV_CNT_W-1:0] r_cnt;
    logic [GAP_W-1:0]     r_rem, n_rem;
    logic [DIV_W-1:0]     r_dvd, n_dvd;

    always_comb begin
        logic [GAP_W:0] t;
        n_rem = r_rem;
        n_dvd = r_dvd;
        t     = '0;
        for (int k = 0; k < DIV_BITS; k++) begin
            t     = {n_rem, n_dvd[DIV_W-1]};
            n_dvd = {n_dvd[DIV_W-2:0], 1'b0};
            if (t >= {1'b0, i_divisor}) begin
                n_rem    = GAP_W'(t - {1'b0, i_divisor});
                n_dvd[0] = 1'b1;
            end else begin
                n_rem = t[GAP_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= DIV_CNT_W'(DIV_CYC);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvd <= DIV_W'(i_dividend);
        end else if (r_cnt != '0) begin
            r_rem <= n_rem;
            r_dvd <= n_dvd;
        end
    end

    assign o_done = (r_cnt == '0);
    assign o_quo  = r_dvd[COL_W-1:0];
    assign o_rem  = r_rem;

endmodule

>>> rtl/stc_dp.sv
// datapath: configuration, column state, flush arithmetic and result register
module stc_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    input  logic [stc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [stc_pkg::BYTE_W-1:0]      i_cfg_data,
    input  logic [stc_pkg::BYTE_W-1:0]      i_in_byte,
    input  stc_pkg::t_cmd                   i_cmd,
    output stc_pkg::t_status                o_status,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output logic [stc_pkg::CNT_W-1:0]       o_fill_count,
    output logic [stc_pkg::CNT_W-1:0]       o_space_count,
    output logic                            o_byte_valid,
    output logic [stc_pkg::BYTE_W-1:0]      o_out_byte,
    output logic [stc_pkg::CNT_W-1:0]       o_column_after
);
    import stc_pkg::*;

    function automatic logic [COL_W-1:0] sat_inc(input logic [COL_W-1:0] v);
        logic [COL_W:0] s;
        s = {1'b0, v} + 1'b1;
        return (s > {1'b0, COL_MAX}) ? COL_MAX : s[COL_W-1:0];
    endfunction

    // configuration (the fill byte value itself is applied by the sink)
    logic             r_compress_enable;
    logic [GAP_W-1:0] r_gap;
    logic             r_single_space;
    logic             r_pass_through;

    // architectural state
    logic [COL_W-1:0] r_column;
    logic [COL_W-1:0] r_held;

    // per-item working registers
    logic [BYTE_W-1:0] r_byte;
    logic [COL_W-1:0]  r_colw;
    logic [COL_W-1:0]  r_h;
    logic [COL_W-1:0]  r_h1;
    logic              r_took;

    // result register
    logic              r_o_valid;
    logic [CNT_W-1:0]  r_o_fill;
    logic [CNT_W-1:0]  r_o_space;
    logic              r_o_bvalid;
    logic [BYTE_W-1:0] r_o_byte;
    logic [CNT_W-1:0]  r_o_col;

    logic is_space, is_nl, is_bs, is_tab, is_print;
    logic [COL_W-1:0] col_a, held_a, pos;
    logic [GAP_W-1:0] ns0;
    logic [COL_W-1:0] h1;
    logic             take;
    logic             div_start, div_done;
    logic [COL_W-1:0] div_dividend, div_quo;
    logic [GAP_W-1:0] div_rem;
    logic [COL_W-1:0] fills, spaces, new_col, space_col;
    logic [COL_W:0]   tab_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_compress_enable <= 1'b0;
            r_gap             <= GAP_RESET;
            r_single_space    <= 1'b0;
            r_pass_through    <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_COMPRESS_ENABLE: r_compress_enable <= i_cfg_data[0];
                CFG_GAP:             r_gap             <= i_cfg_data;
                CFG_SINGLE_SPACE:    r_single_space    <= i_cfg_data[0];
                CFG_PASS_THROUGH:    r_pass_through    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // byte class
    always_comb begin
        is_space = (r_byte == CH_SPACE);
        is_nl    = (r_byte inside {CH_NL, CH_CR});
        is_bs    = (r_byte inside {CH_BS, CH_ESC});
        is_tab   = (r_byte == CH_TAB);
        is_print = (r_byte inside {[CH_PRINT_LO:CH_PRINT_HI]});
    end

    // column and held count before the flush, and where the run began
    always_comb begin
        col_a  = r_column;
        held_a = r_held;
        if (is_nl) begin
            col_a  = '0;
            held_a = '0;
        end else if (is_bs) begin
            if (r_column != '0) col_a  = r_column - 1'b1;
            if (r_held != '0)   held_a = r_held - 1'b1;
        end
        pos = (col_a >= held_a) ? (col_a - held_a) : '0;
    end

    // first fill stop: distance from run start, single space rule
    always_comb begin
        ns0  = r_gap - div_rem;
        take = (CMP_W'(r_h) >= CMP_W'(ns0))
               && !(r_single_space && (ns0 == GAP_W'(1)) && (r_h == COL_W'(1)));
        h1   = COL_W'(CMP_W'(r_h) - CMP_W'(ns0));
    end

    assign div_start    = i_cmd.decide | i_cmd.take_start;
    assign div_dividend = i_cmd.decide ? pos : h1;

    stc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (r_gap),
        .o_done     (div_done),
        .o_quo      (div_quo),
        .o_rem      (div_rem)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_byte <= i_in_byte;
        end
        if (i_cmd.decide) begin
            r_colw <= col_a;
            r_h    <= held_a;
            r_took <= 1'b0;
        end else if (i_cmd.take_start) begin
            r_took <= 1'b1;
            r_h1   <= h1;
        end
    end

    // fill and space split of the flushed run
    always_comb begin
        fills  = '0;
        spaces = r_h;
        if (r_took) begin
            if ((r_gap == GAP_W'(1)) && r_single_space && (r_h1 != '0)) begin
                // last space of the run may not become a fill
                fills  = r_h1;
                spaces = COL_W'(1);
            end else begin
                fills  = div_quo + 1'b1;
                spaces = COL_W'(div_rem);
            end
        end
    end

    // column after a non-space byte
    always_comb begin
        tab_col   = {1'b0, r_colw | TAB_MASK} + 1'b1;
        space_col = sat_inc(r_column);
        new_col   = r_colw;
        if (is_tab) begin
            new_col = (tab_col > {1'b0, COL_MAX}) ? COL_MAX : tab_col[COL_W-1:0];
        end else if (is_print) begin
            new_col = sat_inc(r_colw);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column <= '0;
            r_held   <= '0;
        end else if (i_cmd.finish && !r_pass_through) begin
            if (is_space) begin
                r_column <= space_col;
                r_held   <= sat_inc(r_held);
            end else begin
                r_column <= new_col;
                r_held   <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_o_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            if (r_pass_through) begin
                r_o_fill   <= '0;
                r_o_space  <= '0;
                r_o_bvalid <= 1'b1;
                r_o_byte   <= r_byte;
                r_o_col    <= CNT_W'(r_column);
            end else if (is_space) begin
                r_o_fill   <= '0;
                r_o_space  <= '0;
                r_o_bvalid <= 1'b0;
                r_o_byte   <= '0;
                r_o_col    <= CNT_W'(space_col);
            end else begin
                r_o_fill   <= CNT_W'(fills);
                r_o_space  <= CNT_W'(spaces);
                r_o_bvalid <= 1'b1;
                r_o_byte   <= r_byte;
                r_o_col    <= CNT_W'(new_col);
            end
        end
    end

    always_comb begin
        o_status.need_div = !r_pass_through && !is_space && r_compress_enable
                            && (r_gap != '0) && (held_a != '0);
        o_status.div_done = div_done;
        o_status.take     = take;
        o_status.out_free = !r_o_valid || i_out_ready;
    end

    assign o_out_valid    = r_o_valid;
    assign o_fill_count   = r_o_fill;
    assign o_space_count  = r_o_space;
    assign o_byte_valid   = r_o_bvalid;
    assign o_out_byte     = r_o_byte;
    assign o_column_after = r_o_col;

endmodule

>>> rtl/stc_ctrl.sv
// controller state machine sequencing one byte through the datapath
module stc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  stc_pkg::t_status  i_status,
    output stc_pkg::t_cmd     o_cmd
);
    import stc_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_DECIDE;
            end
            ST_DECIDE: begin
                n_state = i_status.need_div ? ST_MOD : ST_DONE;
            end
            ST_MOD: begin
                if (i_status.div_done) n_state = i_status.take ? ST_DIV : ST_DONE;
            end
            ST_DIV: begin
                if (i_status.div_done) n_state = ST_DONE;
            end
            ST_DONE: begin
                if (i_status.out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready       = 1'b0;
        o_cmd            = '0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_DECIDE: begin
                o_cmd.decide = 1'b1;
            end
            ST_MOD: begin
                o_cmd.take_start = i_status.div_done && i_status.take;
            end
            ST_DIV: ;
            ST_DONE: begin
                o_cmd.finish = i_status.out_free;
            end
            default: ;
        endcase
    end

endmodule

>>> rtl/space_to_tab_output_compressor.sv
// top level of the space-to-tab output compressor
//
// Sits in front of a text output device and takes one byte per input beat.
// Spaces are held back while the output column is tracked; when any other
// byte arrives the held run is flushed and the result beat tells the sink
// how many fill characters (one per fill stop of the configured gap,
// measured from the column where the run began) and how many plain spaces
// to send before the byte itself. Newline and carriage return clear the
// column and drop held spaces, backspace and escape step both back by one,
// tab moves to the next multiple of 8, and the column saturates at
// MAX_COLUMN. A held space produces a beat with byte_valid low. The block
// works on one byte at a time: a held space, a pass-through byte, a byte
// with nothing held, or a flush with compression off or a gap of zero
// takes the decide and done states; a compressed run also takes the
// modulo state, and the divide state too when it reaches a fill stop;
// done waits while the sink stalls a pending result. The extra states
// use the shared divider, which resolves 3 quotient bits per cycle and
// runs once for the run's offset within the gap and once more to split
// the rest into whole gaps. One result beat waits in the output register
// while the next byte is accepted and worked on. Configuration writes
// are always accepted and must only be issued while the block is idle;
// the fill byte value is sent by the sink and not stored here.
module space_to_tab_output_compressor (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration write channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [stc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [stc_pkg::BYTE_W-1:0]      i_cfg_data,
    // input byte channel
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [stc_pkg::BYTE_W-1:0]      i_in_byte,
    // result channel
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [stc_pkg::CNT_W-1:0]       o_fill_count,
    output logic [stc_pkg::CNT_W-1:0]       o_space_count,
    output logic                            o_byte_valid,
    output logic [stc_pkg::BYTE_W-1:0]      o_out_byte,
    output logic [stc_pkg::CNT_W-1:0]       o_column_after
);
    import stc_pkg::*;

    t_cmd    cmd;
    t_status status;

    // register writes are always accepted
    assign o_cfg_ready = 1'b1;

    stc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    stc_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_byte      (i_in_byte),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_out_ready    (i_out_ready),
        .o_out_valid    (o_out_valid),
        .o_fill_count   (o_fill_count),
        .o_space_count  (o_space_count),
        .o_byte_valid   (o_byte_valid),
        .o_out_byte     (o_out_byte),
        .o_column_after (o_column_after)
    );

endmodule

>>> rtl/stc_checker.sv
// port-level checks of the compressor and their binding to the top level
module stc_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_ready,
    input  logic                        i_out_valid,
    input  logic                        i_out_ready,
    input  logic [stc_pkg::CNT_W-1:0]   i_fill_count,
    input  logic [stc_pkg::CNT_W-1:0]   i_space_count,
    input  logic                        i_byte_valid,
    input  logic [stc_pkg::BYTE_W-1:0]  i_out_byte,
    input  logic [stc_pkg::CNT_W-1:0]   i_column_after
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_fill_count)
            && $stable(i_space_count) && $stable(i_byte_valid)
            && $stable(i_out_byte) && $stable(i_column_after))
        else $error("result beat changed while stalled");

    // one byte in flight at a time
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input accepted while a byte is in flight");

    // a held space sends nothing
    a_held_space: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_byte_valid |-> (i_out_byte == '0) && (i_fill_count == '0)
            && (i_space_count == '0))
        else $error("held space beat carries data");

    // fills only come ahead of a byte
    a_fill_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_fill_count != '0) |-> i_byte_valid)
        else $error("fill characters without a byte");

endmodule

bind space_to_tab_output_compressor stc_checker u_stc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .i_in_ready     (o_in_ready),
    .i_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .i_fill_count   (o_fill_count),
    .i_space_count  (o_space_count),
    .i_byte_valid   (o_byte_valid),
    .i_out_byte     (o_out_byte),
    .i_column_after (o_column_after)
);

>>> verif/space_to_tab_output_compressor_tb.sv
// self-checking testbench for the space-to-tab output compressor
module space_to_tab_output_compressor_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import stc_pkg::*;

    // register indexes past the last real register, writes there are dropped
    localparam logic [CFG_IDX_W-1:0] IDX_UNUSED_LO = CFG_PASS_THROUGH + 1'b1;
    localparam logic [CFG_IDX_W-1:0] IDX_UNUSED_HI = {CFG_IDX_W{1'b1}};

    // cycles allowed after the last result beat for stray beats to show up
    localparam int SETTLE_CYCLES = 16;

    // one result beat as seen on the output ports
    typedef struct packed {
        logic [CNT_W-1:0]  fills;
        logic [CNT_W-1:0]  spaces;
        logic              has_ch;
        logic [BYTE_W-1:0] ch;
        logic [CNT_W-1:0]  column;
    } t_beat;

    // tracks column and held spaces, predicts every result beat and
    // checks the beats coming out of the block in order
    class unexpand_scoreboard;
        bit                compress_on;
        logic [BYTE_W-1:0] fill_byte;
        int                stop_gap;
        bit                lone_space_rule;
        bit                pass_mode;
        int                column;
        int                held;
        t_beat             expected_beats[$];
        int                mismatches;

        function new();
            compress_on     = 1'b0;
            fill_byte       = CH_TAB;
            stop_gap        = int'(GAP_RESET);
            lone_space_rule = 1'b0;
            pass_mode       = 1'b0;
            column          = 0;
            held            = 0;
            mismatches      = 0;
        endfunction

        function int clip(int v);
            return (v > MAX_COLUMN) ? MAX_COLUMN : v;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [BYTE_W-1:0] data);
            case (idx)
                CFG_COMPRESS_ENABLE: compress_on     = data[0];
                CFG_FILL_CHAR:       fill_byte       = data;
                CFG_GAP:             stop_gap        = int'(data);
                CFG_SINGLE_SPACE:    lone_space_rule = data[0];
                CFG_PASS_THROUGH:    pass_mode       = data[0];
                default: ;
            endcase
        endfunction

        function t_beat flush_and_send(logic [BYTE_W-1:0] b);
            t_beat r;
            int    h, pos, step, fills, spaces;
            bit    take;
            r      = '0;
            fills  = 0;
            spaces = 0;
            if (pass_mode) begin
                r.has_ch = 1'b1;
                r.ch     = b;
                r.column = CNT_W'(column);
                return r;
            end
            if (b == CH_SPACE) begin
                held     = clip(held + 1);
                column   = clip(column + 1);
                r.column = CNT_W'(column);
                return r;
            end
            if (b == CH_NL || b == CH_CR) begin
                column = 0;
                held   = 0;
            end else if (b == CH_BS || b == CH_ESC) begin
                if (column > 0) column--;
                if (held > 0) held--;
            end
            // walk the held run from the column where it started
            h   = held;
            pos = (column >= h) ? column - h : 0;
            while (h > 0) begin
                take = 1'b0;
                step = 1;
                if (compress_on && stop_gap != 0) begin
                    step = stop_gap - (pos % stop_gap);
                    if (h >= step && (!lone_space_rule || step > 1 || h > 1))
                        take = 1'b1;
                end
                if (take) begin
                    h -= step;
                    pos += step;
                    fills++;
                end else begin
                    h--;
                    pos++;
                    spaces++;
                end
            end
            held = 0;
            if (b == CH_TAB)
                column = clip((column | int'(TAB_MASK)) + 1);
            else if (b >= CH_PRINT_LO && b <= CH_PRINT_HI)
                column = clip(column + 1);
            r.fills  = CNT_W'(fills);
            r.spaces = CNT_W'(spaces);
            r.has_ch = 1'b1;
            r.ch     = b;
            r.column = CNT_W'(column);
            return r;
        endfunction

        function void note_byte(logic [BYTE_W-1:0] b);
            expected_beats.push_back(flush_and_send(b));
        endfunction

        function void check_beat(t_beat got);
            t_beat want;
            if (expected_beats.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected beat %0d %0d %b %h %0d",
                             $realtime, got.fills, got.spaces, got.has_ch, got.ch, got.column);
                return;
            end
            want = expected_beats.pop_front();
            if (got.fills !== want.fills || got.spaces !== want.spaces ||
                got.has_ch !== want.has_ch || got.ch !== want.ch ||
                got.column !== want.column) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: expected %0d %0d %b %h %0d, got %0d %0d %b %h %0d",
                             $realtime, want.fills, want.spaces, want.has_ch, want.ch,
                             want.column, got.fills, got.spaces, got.has_ch, got.ch, got.column);
            end
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [BYTE_W-1:0]    i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic [BYTE_W-1:0]    i_in_byte;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic [CNT_W-1:0]     o_fill_count;
    logic [CNT_W-1:0]     o_space_count;
    logic                 o_byte_valid;
    logic [BYTE_W-1:0]    o_out_byte;
    logic [CNT_W-1:0]     o_column_after;

    unexpand_scoreboard sb = new();

    // per-phase switches for back-to-back traffic on either side
    bit src_calm;
    bit sink_calm;
    int items_sent;
    t_beat seen_beat;

    space_to_tab_output_compressor dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_in_byte      (i_in_byte),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_fill_count   (o_fill_count),
        .o_space_count  (o_space_count),
        .o_byte_valid   (o_byte_valid),
        .o_out_byte     (o_out_byte),
        .o_column_after (o_column_after)
    );

    // 20 ns clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // run limit, far above the slowest legal run
    initial begin
        #10_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    // monitor: every handshake is seen on the edge where it completes,
    // before the edge's nonblocking updates land
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready)
                sb.write_reg(i_cfg_index, i_cfg_data);
            if (i_in_valid && o_in_ready)
                sb.note_byte(i_in_byte);
            if (o_out_valid && i_out_ready) begin
                seen_beat.fills  = o_fill_count;
                seen_beat.spaces = o_space_count;
                seen_beat.has_ch = o_byte_valid;
                seen_beat.ch     = o_out_byte;
                seen_beat.column = o_column_after;
                sb.check_beat(seen_beat);
            end
        end
    end

    // result sink: random stall before each beat, none in calm phases;
    // ready stays high across back-to-back beats
    initial begin
        int stall;
        i_out_ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            stall = sink_calm ? 0 : $urandom_range(0, 14);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    // one input beat; valid is only dropped when a gap is drawn, so a
    // back-to-back beat never sees valid lowered and raised in one step
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int idle;
        idle = src_calm ? 0 : $urandom_range(0, 14);
        if (idle > 0) begin
            i_in_valid <= 1'b0;
            repeat (idle) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_byte  <= b;
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
    endtask

    // stop sending and wait until every predicted beat has been checked
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_beats.size() != 0) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // full register set, sometimes preceded by a write to an unused index
    task automatic program_regs(input bit en, input logic [BYTE_W-1:0] fill,
                                input logic [BYTE_W-1:0] gap_cols, input bit lone, input bit thru);
        if ($urandom_range(0, 3) == 0)
            cfg_write(CFG_IDX_W'($urandom_range(IDX_UNUSED_LO, IDX_UNUSED_HI)),
                      BYTE_W'($urandom));
        cfg_write(CFG_COMPRESS_ENABLE, {7'd0, en});
        cfg_write(CFG_FILL_CHAR, fill);
        cfg_write(CFG_GAP, gap_cols);
        cfg_write(CFG_SINGLE_SPACE, {7'd0, lone});
        cfg_write(CFG_PASS_THROUGH, {7'd0, thru});
        i_cfg_valid <= 1'b0;
    endtask

    // one piece of text: words, space runs, tabs, line ends, edits, noise
    task automatic send_text_token(input bit long_line);
        int pick, len;
        pick = $urandom_range(0, 99);
        if (pick < 38) begin
            len = $urandom_range(1, 8);
            repeat (len) send_byte(BYTE_W'($urandom_range(CH_PRINT_LO, CH_PRINT_HI)));
        end else if (pick < 62) begin
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 9);
            repeat (len) send_byte(CH_SPACE);
        end else if (pick < 72) begin
            send_byte(CH_TAB);
        end else if (pick < 78) begin
            send_byte($urandom_range(0, 1) ? CH_BS : CH_ESC);
        end else if (pick < 86) begin
            if (!long_line) send_byte($urandom_range(0, 1) ? CH_NL : CH_CR);
        end else begin
            len = $urandom_range(1, 3);
            repeat (len) send_byte(BYTE_W'($urandom_range(0, 255)));
        end
    endtask

    initial begin
        logic [BYTE_W-1:0] opening[$];
        logic [BYTE_W-1:0] fill, gap_cols;
        bit                en, lone, thru, long_line, paused_mid;
        int                phase_len, phase_end;

        // every input known from time zero, then reset is held and released
        i_rst_n     <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        i_in_valid  <= 1'b0;
        i_in_byte   <= '0;
        src_calm    = 1'b0;
        sink_calm   = 1'b0;
        items_sent  = 0;
        paused_mid  = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: compression off, held spaces leave as spaces
        opening = '{8'h61, CH_SPACE, CH_SPACE, 8'h62};
        foreach (opening[k]) send_byte(opening[k]);
        drain_results();

        // compression on at the usual stops: a run reaching a stop, a space
        // undone by backspace and by escape, line ends dropping held
        // spaces, and the byte extremes
        program_regs(1'b1, CH_TAB, GAP_RESET, 1'b0, 1'b0);
        opening = '{CH_TAB, CH_SPACE, CH_SPACE, CH_SPACE, CH_SPACE, CH_SPACE, CH_SPACE,
                    CH_SPACE, CH_SPACE, 8'h71, CH_SPACE, CH_BS, CH_SPACE, CH_ESC, CH_NL,
                    CH_SPACE, CH_SPACE, CH_CR, 8'h00, 8'hFF};
        foreach (opening[k]) send_byte(opening[k]);
        drain_results();

        // a run long enough to saturate both the column and the held count
        program_regs(1'b1, 8'hFF, 8'd1, 1'b0, 1'b0);
        src_calm  = 1'b1;
        sink_calm = 1'b1;
        repeat (MAX_COLUMN + 2) send_byte(CH_SPACE);
        send_byte(8'h78);
        send_byte(CH_TAB);
        drain_results();

        // random phases, each with its own register set
        while (items_sent < 1150) begin
            en = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 7))
                0:       gap_cols = 8'd0;
                1:       gap_cols = 8'd1;
                2:       gap_cols = 8'd255;
                3:       gap_cols = GAP_RESET;
                4:       gap_cols = 8'd2;
                default: gap_cols = BYTE_W'($urandom_range(1, 16));
            endcase
            case ($urandom_range(0, 3))
                0:       fill = 8'h00;
                1:       fill = 8'hFF;
                default: fill = BYTE_W'($urandom_range(0, 255));
            endcase
            lone      = ($urandom_range(0, 1) != 0);
            thru      = ($urandom_range(0, 5) == 0);
            long_line = ($urandom_range(0, 3) == 0);
            src_calm  = ($urandom_range(0, 4) == 0);
            sink_calm = ($urandom_range(0, 4) == 0);
            program_regs(en, fill, gap_cols, lone, thru);

            phase_len = $urandom_range(20, 90);
            phase_end = items_sent + phase_len;
            while (items_sent < phase_end) begin
                send_text_token(long_line);
                // once mid-phase, let the pipeline run dry before going on
                if (!paused_mid && items_sent > 600) begin
                    drain_results();
                    paused_mid = 1'b1;
                end
            end
            drain_results();
        end

        // settle, then report
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.expected_beats.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
